>>> rtl/core/gpio_po_pkg.sv
package gpio_po_pkg;

	localparam int PIN_COUNT_DEF  = 32;
	localparam int OWNER_BITS_DEF = 16;

	localparam int PIN_NUM_W  = 6;
	localparam int REQ_W      = 16;
	localparam int OPERAND_W  = 8;
	localparam int LEVELS_W   = 32;
	localparam int FUNC_W     = 4;
	localparam int STATUS_W   = 3;
	localparam int S_DATA_W   = 64;
	localparam int M_DATA_W   = 72;
	localparam int PADDR_W    = 3;

	localparam logic [31:0] MASK_RESET = 32'hFBC6CF9C;

	localparam logic [OPERAND_W-1:0] DIR_IN_CODE  = 8'd0;
	localparam logic [OPERAND_W-1:0] DIR_OUT_CODE = 8'd1;

	typedef enum logic [FUNC_W-1:0] {
		FN_READ        = 4'd0,
		FN_WRITE       = 4'd1,
		FN_REQUEST     = 4'd2,
		FN_FREE        = 4'd3,
		FN_TOGGLE      = 4'd4,
		FN_MODE        = 4'd5,
		FN_SET         = 4'd6,
		FN_CLEAR       = 4'd7,
		FN_RELEASE_ALL = 4'd8
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_PIN   = 3'd1,
		ST_NOT_OWNER = 3'd2,
		ST_RESERVED  = 3'd3,
		ST_INVALID   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

endpackage

>>> rtl/core/gpio_with_pin_ownership_top.sv
// Channel   Direction  Handshake          Contents
// s_*       in         tvalid/tready      one operation beat
// m_*       out        tvalid/tready      one result beat per operation
// apb       in/out     psel/penable       reservable_pin_mask at address 0
//
// An operation is captured, then executed against the owner table.
// The owner table, latch and direction sit in flip-flops, read and written in
// the execute cycle; release-all compares all owners in that same cycle.
// Execution holds while a previous result waits on m_tready.
// Reset clears owners, latch and direction and loads the mask reset value.
module gpio_with_pin_ownership_top
	import gpio_po_pkg::*;
#(
	parameter int PIN_COUNT  = PIN_COUNT_DEF,
	parameter int OWNER_BITS = OWNER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// pin_number[5:0], requester_id[21:6], operand_value[29:22], sampled_levels[61:30]
	input  logic [S_DATA_W-1:0] s_tdata,
	// func[3:0]
	input  logic [FUNC_W-1:0]   s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// bit_result[0], drive_levels[32:1], output_enables[64:33]
	output logic [M_DATA_W-1:0] m_tdata,
	// status[2:0]
	output logic [STATUS_W-1:0] m_tuser,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	cmd_t        cmd;
	logic        cfg_we;
	logic [31:0] mask;
	logic        bit_result;
	logic [31:0] drive_levels;
	logic [31:0] output_enables;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : mask;

	gpio_po_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	gpio_po_dp #(
		.PIN_COUNT  (PIN_COUNT),
		.OWNER_BITS (OWNER_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.in_data        (s_tdata),
		.in_func        (s_tuser),
		.cfg_we         (cfg_we),
		.cfg_wdata      (pwdata),
		.mask           (mask),
		.status         (m_tuser),
		.bit_result     (bit_result),
		.drive_levels   (drive_levels),
		.output_enables (output_enables)
	);

	assign m_tdata = {7'd0, output_enables, drive_levels, bit_result};

endmodule

>>> rtl/core/gpio_po_ctrl.sv
module gpio_po_ctrl
	import gpio_po_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd
);

	state_t state_q;
	logic   out_valid_q;
	logic   commit;

	assign s_tready = (state_q == S_IDLE);
	assign commit   = (state_q == S_EXEC) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;

	assign cmd.load   = s_tvalid && s_tready;
	assign cmd.commit = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_EXEC)
		else $error("accepted beat did not start execution");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC && m_tvalid && !m_tready |=> state_q == S_EXEC && m_tvalid)
		else $error("result committed over an untaken beat");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid && state_q == S_IDLE)
		else $error("commit did not present a result");

endmodule

>>> rtl/core/gpio_po_dp.sv
module gpio_po_dp
	import gpio_po_pkg::*;
#(
	parameter int PIN_COUNT  = PIN_COUNT_DEF,
	parameter int OWNER_BITS = OWNER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [S_DATA_W-1:0] in_data,
	input  logic [FUNC_W-1:0]   in_func,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	output logic [31:0]         mask,
	output logic [STATUS_W-1:0] status,
	output logic                bit_result,
	output logic [31:0]         drive_levels,
	output logic [31:0]         output_enables
);

	localparam int PIN_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

	typedef logic [OWNER_BITS-1:0] owner_t;

	logic [FUNC_W-1:0]    func_q;
	logic [PIN_NUM_W-1:0] pin_q;
	logic [REQ_W-1:0]     req_q;
	logic [OPERAND_W-1:0] operand_q;
	logic [LEVELS_W-1:0]  levels_q;

	logic [31:0]          mask_q;
	logic [31:0]          latch_q;
	logic [31:0]          dir_q;
	owner_t               owner_q [PIN_COUNT];
	logic [STATUS_W-1:0]  status_q;
	logic                 bit_q;

	owner_t               who;
	logic [PIN_W-1:0]     idx;
	logic                 pin_ok;
	logic [31:0]          sel;
	owner_t               cur_owner;

	status_t              status_d;
	logic                 bit_d;
	logic [31:0]          latch_d;
	logic [31:0]          dir_d;
	logic                 own_wr;
	owner_t               own_wdata;
	logic                 release_all;

	assign who       = OWNER_BITS'(req_q);
	assign idx       = pin_q[PIN_W-1:0];
	assign pin_ok    = (pin_q < PIN_NUM_W'(PIN_COUNT)) && mask_q[pin_q[4:0]];
	assign sel       = 32'd1 << pin_q[4:0];
	assign cur_owner = owner_q[idx];

	always_comb begin
		status_d    = ST_OK;
		bit_d       = 1'b0;
		latch_d     = latch_q;
		dir_d       = dir_q;
		own_wr      = 1'b0;
		own_wdata   = '0;
		release_all = 1'b0;
		if (func_q == FN_READ) begin
			bit_d = levels_q[pin_q[4:0]];
		end else if (func_q == FN_RELEASE_ALL) begin
			release_all = 1'b1;
		end else if (func_q > FN_RELEASE_ALL) begin
			status_d = ST_INVALID;
		end else if (!pin_ok) begin
			status_d = ST_BAD_PIN;
		end else if (func_q == FN_REQUEST) begin
			if (cur_owner != '0) begin
				status_d = ST_RESERVED;
			end else begin
				own_wr    = 1'b1;
				own_wdata = who;
			end
		end else if (cur_owner != who) begin
			status_d = ST_NOT_OWNER;
		end else begin
			case (func_q)
				FN_WRITE: begin
					latch_d = (operand_q != '0) ? (latch_q | sel) : (latch_q & ~sel);
				end
				FN_FREE: begin
					own_wr = 1'b1;
				end
				FN_TOGGLE: begin
					bit_d   = ~levels_q[pin_q[4:0]];
					latch_d = bit_d ? (latch_q | sel) : (latch_q & ~sel);
				end
				FN_MODE: begin
					dir_d = dir_q & ~sel;
					if (operand_q == DIR_OUT_CODE) begin
						dir_d = dir_q | sel;
					end else if (operand_q != DIR_IN_CODE) begin
						status_d = ST_INVALID;
					end
				end
				FN_SET: begin
					latch_d = latch_q | sel;
				end
				default: begin
					latch_d = latch_q & ~sel;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= in_func;
			pin_q     <= in_data[5:0];
			req_q     <= in_data[21:6];
			operand_q <= in_data[29:22];
			levels_q  <= in_data[61:30];
		end
		if (cmd.commit) begin
			status_q <= status_d;
			bit_q    <= bit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= MASK_RESET;
			latch_q <= '0;
			dir_q   <= '0;
			for (int i = 0; i < PIN_COUNT; i++) begin
				owner_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				latch_q <= latch_d;
				dir_q   <= dir_d;
				for (int i = 0; i < PIN_COUNT; i++) begin
					if (release_all && owner_q[i] == who) begin
						owner_q[i] <= '0;
					end
				end
				if (own_wr) begin
					owner_q[idx] <= own_wdata;
				end
			end
		end
	end

	assign mask           = mask_q;
	assign status         = status_q;
	assign bit_result     = bit_q;
	assign drive_levels   = latch_q;
	assign output_enables = dir_q;

	a_request_owns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && func_q == FN_REQUEST && status_d == ST_OK
		|=> owner_q[$past(idx)] == $past(who))
		else $error("granted request not recorded");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (status_d == ST_BAD_PIN || status_d == ST_NOT_OWNER ||
		status_d == ST_RESERVED) |=> $stable(latch_q) && $stable(dir_q))
		else $error("failed check changed pin state");

	a_bit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && status_d != ST_OK |=> !bit_result)
		else $error("bit result set on failed operation");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import gpio_po_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_PIN_MASK = 3'd0;
	localparam int                 IDLE_LIMIT    = 2000;
	localparam int                 DRAIN_CYCLES  = 8;
	localparam int                 CFG_SETTLE    = 4;

	typedef struct {
		logic [FUNC_W-1:0]    fn;
		logic [PIN_NUM_W-1:0] pin;
		logic [REQ_W-1:0]     who;
		logic [OPERAND_W-1:0] opnd;
		logic [LEVELS_W-1:0]  levels;
	} gpio_op_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic                level_bit;
		logic [31:0]         drive_levels;
		logic [31:0]         output_enables;
	} gpio_result_t;

	typedef enum {RX_FREE, RX_MOSTLY, RX_HALF, RX_SLOW} rx_mode_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [FUNC_W-1:0]   s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [PADDR_W-1:0]  paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic [31:0]         prdata;
	logic                pready;

	logic [REQ_W-1:0] owner_of [PIN_COUNT_DEF];
	logic [31:0]      pin_mask_model = MASK_RESET;
	logic [31:0]      latch_model    = '0;
	logic [31:0]      dir_model      = '0;

	gpio_result_t pending_results[$];
	gpio_result_t want;
	int unsigned  fail_count = 0;
	int unsigned  burst_left = 0;
	int unsigned  hold_req   = 0;
	int unsigned  hold_left  = 0;
	int unsigned  rx_left    = 0;
	int unsigned  idle_cycles = 0;
	rx_mode_t     rx_mode    = RX_FREE;

	gpio_with_pin_ownership_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic gpio_result_t apply_gpio_op(input gpio_op_t op);
		gpio_result_t res;
		logic [4:0]   p;
		p = op.pin[4:0];
		res.status = ST_OK;
		res.level_bit = 1'b0;
		if (op.fn == FN_READ) begin
			res.level_bit = op.levels[p];
		end else if (op.fn == FN_RELEASE_ALL) begin
			for (int i = 0; i < PIN_COUNT_DEF; i++)
				if (owner_of[i] == op.who)
					owner_of[i] = '0;
		end else if (op.fn > FN_RELEASE_ALL) begin
			res.status = ST_INVALID;
		end else if (op.pin >= PIN_COUNT_DEF || !pin_mask_model[p]) begin
			res.status = ST_BAD_PIN;
		end else if (op.fn == FN_REQUEST) begin
			if (owner_of[p] != '0)
				res.status = ST_RESERVED;
			else
				owner_of[p] = op.who;
		end else if (owner_of[p] != op.who) begin
			res.status = ST_NOT_OWNER;
		end else begin
			case (op.fn)
				FN_WRITE: latch_model[p] = (op.opnd != '0);
				FN_FREE: owner_of[p] = '0;
				FN_TOGGLE: begin
					res.level_bit = ~op.levels[p];
					latch_model[p] = res.level_bit;
				end
				FN_MODE: begin
					dir_model[p] = 1'b0;
					if (op.opnd == DIR_OUT_CODE)
						dir_model[p] = 1'b1;
					else if (op.opnd != DIR_IN_CODE)
						res.status = ST_INVALID;
				end
				FN_SET: latch_model[p] = 1'b1;
				default: latch_model[p] = 1'b0;
			endcase
		end
		res.drive_levels = latch_model;
		res.output_enables = dir_model;
		return res;
	endfunction

	task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [PIN_NUM_W-1:0] pin,
			input logic [REQ_W-1:0] who, input logic [OPERAND_W-1:0] opnd,
			input logic [LEVELS_W-1:0] levels);
		gpio_op_t    op;
		int unsigned gap;
		op.fn = fn;
		op.pin = pin;
		op.who = who;
		op.opnd = opnd;
		op.levels = levels;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 4) < 3) begin
				gap = $urandom_range(1, 8);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {2'b00, levels, opnd, who, pin};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_gpio_op(op));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_pin_mask(input logic [31:0] value);
		wait_drained();
		repeat (CFG_SETTLE) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_PIN_MASK;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pin_mask_model = value;
	endtask

	task automatic test_directed();
		logic [REQ_W-1:0] id_a;
		logic [REQ_W-1:0] id_b;
		id_a = 16'h1234;
		id_b = 16'hFFFF;
		send_op(FN_READ, 6'd63, id_a, 8'h00, 32'h8000_0000);
		send_op(FN_READ, 6'd0, id_b, 8'hFF, 32'hFFFF_FFFE);
		send_op(FN_REQUEST, 6'd0, id_a, 8'h00, 32'h0);
		send_op(FN_REQUEST, 6'd32, id_a, 8'h00, 32'h0);
		send_op(FN_REQUEST, 6'd2, id_a, 8'h00, 32'h0);
		send_op(FN_REQUEST, 6'd2, id_b, 8'h00, 32'h0);
		send_op(FN_WRITE, 6'd2, id_b, 8'h01, 32'h0);
		send_op(FN_WRITE, 6'd2, id_a, 8'hFF, 32'h0);
		send_op(FN_WRITE, 6'd2, id_a, 8'h00, 32'hFFFF_FFFF);
		send_op(FN_TOGGLE, 6'd2, id_a, 8'h00, 32'h0);
		send_op(FN_TOGGLE, 6'd2, id_a, 8'h00, 32'hFFFF_FFFF);
		send_op(FN_MODE, 6'd2, id_a, DIR_OUT_CODE, 32'h0);
		send_op(FN_MODE, 6'd2, id_a, 8'hFF, 32'h0);
		send_op(FN_MODE, 6'd2, id_a, DIR_OUT_CODE, 32'h0);
		send_op(FN_MODE, 6'd2, id_a, DIR_IN_CODE, 32'h0);
		send_op(FN_SET, 6'd2, id_a, 8'h00, 32'h0);
		send_op(FN_REQUEST, 6'd31, id_b, 8'h00, 32'h0);
		send_op(FN_SET, 6'd31, id_b, 8'h00, 32'h0);
		send_op(FN_CLEAR, 6'd2, id_a, 8'h00, 32'h0);
		send_op(FN_FREE, 6'd2, id_b, 8'h00, 32'h0);
		send_op(FN_FREE, 6'd2, id_a, 8'h00, 32'h0);
		send_op(FN_REQUEST, 6'd3, '0, 8'h00, 32'h0);
		send_op(FN_SET, 6'd3, '0, 8'h00, 32'h0);
		send_op(FN_RELEASE_ALL + 4'd1, 6'd4, id_a, 8'h00, 32'h0);
		send_op('1, 6'd63, id_a, 8'hFF, 32'hFFFF_FFFF);
		send_op(FN_REQUEST, 6'd4, id_a, 8'h00, 32'h0);
		send_op(FN_RELEASE_ALL, 6'd63, id_a, 8'h00, 32'h0);
		send_op(FN_REQUEST, 6'd4, id_b, 8'h00, 32'h0);
		send_op(FN_RELEASE_ALL, 6'd0, id_b, 8'h00, 32'h0);
	endtask

	task automatic test_mask_extremes();
		write_pin_mask('0);
		send_op(FN_REQUEST, 6'd2, 16'h0101, 8'h00, 32'h0);
		send_op(FN_READ, 6'd5, 16'h0101, 8'h00, 32'h0000_0020);
		write_pin_mask('1);
		send_op(FN_REQUEST, 6'd0, 16'h0101, 8'h00, 32'h0);
		send_op(FN_REQUEST, 6'd31, 16'h0101, 8'h00, 32'h0);
		send_op(FN_SET, 6'd0, 16'h0101, 8'h00, 32'h0);
		write_pin_mask(32'hFFFF_FFFE);
		send_op(FN_CLEAR, 6'd0, 16'h0101, 8'h00, 32'h0);
		send_op(FN_RELEASE_ALL, 6'd0, 16'h0101, 8'h00, 32'h0);
		write_pin_mask('1);
		send_op(FN_REQUEST, 6'd0, 16'h0202, 8'h00, 32'h0);
		send_op(FN_CLEAR, 6'd0, 16'h0202, 8'h00, 32'h0);
		send_op(FN_RELEASE_ALL, 6'd0, 16'h0202, 8'h00, 32'h0);
		write_pin_mask(MASK_RESET);
	endtask

	task automatic test_random_ops(input int unsigned n_ops);
		logic [REQ_W-1:0]     pool [3];
		int unsigned          r;
		logic [FUNC_W-1:0]    fn;
		logic [PIN_NUM_W-1:0] pin;
		logic [REQ_W-1:0]     who;
		logic [OPERAND_W-1:0] opnd;
		pool[0] = REQ_W'($urandom);
		pool[1] = REQ_W'($urandom);
		case ($urandom_range(0, 3))
			0: pool[2] = '1;
			1: pool[2] = '0;
			2: pool[2] = 16'h0001;
			default: pool[2] = 16'h0002;
		endcase
		repeat (n_ops) begin
			r = $urandom_range(0, 99);
			if (r < 8) fn = FN_READ;
			else if (r < 24) fn = FN_REQUEST;
			else if (r < 31) fn = FN_FREE;
			else if (r < 43) fn = FN_WRITE;
			else if (r < 55) fn = FN_TOGGLE;
			else if (r < 67) fn = FN_MODE;
			else if (r < 77) fn = FN_SET;
			else if (r < 87) fn = FN_CLEAR;
			else if (r < 91) fn = FN_RELEASE_ALL;
			else if (r < 94)
				fn = FUNC_W'($urandom_range(int'(FN_RELEASE_ALL) + 1, (1 << FUNC_W) - 1));
			else fn = FN_REQUEST;
			pin = ($urandom_range(0, 19) == 0) ? PIN_NUM_W'($urandom_range(32, 63))
				: PIN_NUM_W'($urandom_range(0, 31));
			who = pool[$urandom_range(0, 2)];
			if (fn inside {FN_WRITE, FN_FREE, FN_TOGGLE, FN_MODE, FN_SET, FN_CLEAR} &&
					pin < PIN_COUNT_DEF && $urandom_range(0, 9) < 7)
				who = owner_of[pin[4:0]];
			if ($urandom_range(0, 49) == 0)
				who = REQ_W'($urandom);
			if (fn == FN_MODE) begin
				r = $urandom_range(0, 19);
				opnd = (r < 9) ? DIR_IN_CODE : (r < 18) ? DIR_OUT_CODE
					: OPERAND_W'($urandom_range(2, 255));
			end else begin
				opnd = ($urandom_range(0, 3) == 0) ? '0 : OPERAND_W'($urandom);
			end
			send_op(fn, pin, who, opnd, $urandom);
		end
	endtask

	task automatic test_output_stall();
		hold_req <= 150;
		test_random_ops(40);
		wait_drained();
	endtask

	task automatic test_input_pause();
		test_random_ops(20);
		wait_drained();
		test_random_ops(20);
	endtask

	task automatic test_random_phases();
		logic [31:0] mask;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0, 7: mask = MASK_RESET;
				1, 5: mask = '1;
				3: mask = '0;
				4: mask = $urandom | $urandom;
				default: mask = $urandom;
			endcase
			write_pin_mask(mask);
			test_random_ops(ph == 3 ? 30 : 100);
		end
	endtask

	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req <= 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 64);
			end
			rx_left--;
			case (rx_mode)
				RX_FREE: m_tready <= 1'b1;
				RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
				RX_HALF: m_tready <= ($urandom_range(0, 1) != 0);
				default: m_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no pending operation");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					fail_count++;
				end
				if (m_tdata[0] !== want.level_bit) begin
					$error("bit_result: expected %0d, got %0d", want.level_bit, m_tdata[0]);
					fail_count++;
				end
				if (m_tdata[32:1] !== want.drive_levels) begin
					$error("drive_levels: expected %h, got %h", want.drive_levels, m_tdata[32:1]);
					fail_count++;
				end
				if (m_tdata[64:33] !== want.output_enables) begin
					$error("output_enables: expected %h, got %h", want.output_enables,
						m_tdata[64:33]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < PIN_COUNT_DEF; i++)
			owner_of[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_mask_extremes();
		test_output_stall();
		test_input_pause();
		test_random_phases();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
